### src/distance_vector_route_update_assert.svh
// ----------------------------------------------------------------------------
// distance vector route update assertion macros
// concurrent checks on clk with synchronous reset rst
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH

`ifndef SYNTHESIS
`define DVRU_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dvru assertion failed");
`define DVRU_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dvru assertion failed");
`else
`define DVRU_ASSERT_IMP(name, pre, post)
`define DVRU_ASSERT_NXT(name, pre, post)
`endif

`endif

### src/dvru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvru_pkg
// shared constants, codes and payload types of the route update engine
// ----------------------------------------------------------------------------
package dvru_pkg;

  localparam int TableDepth    = 16;
  localparam int NodeIdBits    = 8;
  localparam int CountW        = $clog2(TableDepth + 1);
  localparam int IdFieldW      = 8;
  localparam int CostW         = 16;
  localparam int ReadIdxW      = 4;
  localparam int ActW          = 2;
  localparam int StatusW       = 3;
  localparam int RouteCountW   = 5;
  localparam int CfgIdxW       = 1;
  localparam int CfgDataW      = 16;
  localparam logic [CostW-1:0] InfinityReset = 16'd9999;

  typedef enum logic [ActW-1:0] {
    ACT_UPDATE  = 2'd0,
    ACT_INSTALL = 2'd1,
    ACT_READ    = 2'd2
  } act_t;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED      = 3'd0,
    ST_IMPROVED   = 3'd1,
    ST_NOT_BETTER = 3'd2,
    ST_SELF       = 3'd3,
    ST_UNREACH    = 3'd4,
    ST_FULL       = 3'd5,
    ST_READ_OK    = 3'd6,
    ST_READ_BAD   = 3'd7
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OWN_ID   = 1'b0,
    CFG_INFINITY = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic [ActW-1:0]     action;
    logic [IdFieldW-1:0] sender_node;
    logic [IdFieldW-1:0] dest_node;
    logic [CostW-1:0]    adv_cost;
    logic [CostW-1:0]    link_cost;
    logic [ReadIdxW-1:0] read_index;
    logic                last;
  } req_item_t;

  typedef struct packed {
    logic [StatusW-1:0]     status;
    logic [IdFieldW-1:0]    entry_dest;
    logic [CostW-1:0]       entry_cost;
    logic [IdFieldW-1:0]    entry_next_hop;
    logic [RouteCountW-1:0] route_count;
    logic                   vector_changed;
  } rsp_item_t;

  // query travelling down the cell row
  typedef struct packed {
    logic                  valid;
    act_t                  act;
    logic [NodeIdBits-1:0] dest;
    logic [NodeIdBits-1:0] sender;
    logic [CostW-1:0]      cost;
    logic [ReadIdxW-1:0]   ridx;
    logic                  hit;
    status_t               status;
    logic [NodeIdBits-1:0] e_dest;
    logic [CostW-1:0]      e_cost;
    logic [NodeIdBits-1:0] e_hop;
  } query_t;

endpackage

### src/dvru_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvru channel interfaces
// valid/ready channels for request and response transactions
// ----------------------------------------------------------------------------
interface dvru_req_if import dvru_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dvru_rsp_if import dvru_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/dvru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvru_cell
// one route table entry; matches, improves, appends or reads as the query
// passes and, through its q_out register, hands the query to the next cell the cycle after, never later
// ----------------------------------------------------------------------------
module dvru_cell import dvru_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CountW-1:0] cell_index,
  input  logic [CountW-1:0] route_total,
  input  query_t            q_in,
  output query_t            q_out
);

  logic [NodeIdBits-1:0] dest_r;
  logic [CostW-1:0]      cost_r;
  logic [NodeIdBits-1:0] hop_r;
  logic [NodeIdBits-1:0] wr_dest;
  logic                  wr;
  query_t                q_next;

  always_comb begin
    q_next  = q_in;
    wr      = 1'b0;
    wr_dest = q_in.dest;
    if (q_in.valid && !q_in.hit) begin
      unique case (q_in.act) inside
        ACT_UPDATE, ACT_INSTALL: begin
          if (q_in.act == ACT_UPDATE && cell_index < route_total &&
              dest_r == q_in.dest) begin
            q_next.hit = 1'b1;
            if (q_in.cost < cost_r) begin
              wr             = 1'b1;
              wr_dest        = dest_r;
              q_next.status  = ST_IMPROVED;
              q_next.e_dest  = dest_r;
              q_next.e_cost  = q_in.cost;
              q_next.e_hop   = q_in.sender;
            end else begin
              q_next.status  = ST_NOT_BETTER;
              q_next.e_dest  = dest_r;
              q_next.e_cost  = cost_r;
              q_next.e_hop   = hop_r;
            end
          end else if (cell_index == route_total) begin
            wr            = 1'b1;
            q_next.hit    = 1'b1;
            q_next.status = ST_ADDED;
            q_next.e_dest = q_in.dest;
            q_next.e_cost = q_in.cost;
            q_next.e_hop  = q_in.sender;
          end
        end
        ACT_READ: begin
          if (cell_index == CountW'(q_in.ridx)) begin
            q_next.hit    = 1'b1;
            q_next.status = ST_READ_OK;
            q_next.e_dest = dest_r;
            q_next.e_cost = cost_r;
            q_next.e_hop  = hop_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      dest_r <= wr_dest;
      cost_r <= q_in.cost;
      hop_r  <= q_in.sender;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out <= '0;
    end else begin
      q_out <= q_next;
    end
  end

endmodule

### src/distance_vector_route_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_update
// distance-vector routing table engine: relaxes advertised entries, installs
// neighbor routes and exports entries through a row of table cells
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    action, ids, costs, read_index, last
//  rsp      out  valid/ready    status, entry, route_count, vector_changed
//  cfg      in   cfg_we         cfg_index, cfg_data
//
//  searches, installs and reads of entries 1..15 walk the row of 15 cells,
//  one cell a cycle, then the result and response registers take the answer;
//  self, unreachable, self-entry reads, bad reads and unknown actions skip the
//  row and go from the result register to the response register
//  one item is in work at a time; a waiting response does not block the next
//  rsp stalls hold the response register; the table starts with the self entry
// ----------------------------------------------------------------------------
`include "distance_vector_route_update_assert.svh"

module distance_vector_route_update import dvru_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  dvru_req_if.sink            req,
  dvru_rsp_if.source          rsp,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [IdFieldW-1:0]   own_id;
  logic [CostW-1:0]      infinity;
  logic [CountW-1:0]     total;
  logic [CountW-1:0]     total_next;
  logic                  changed_flag;
  logic                  flag_next;
  state_t                state;
  state_t                state_next;
  logic                  item_update;
  logic                  item_last;
  rsp_item_t             res;
  rsp_item_t             res_next;
  query_t                head;
  query_t                head_next;
  query_t                tail;
  query_t                row [TableDepth];
  logic                  accept;
  logic                  out_load;
  logic [CostW:0]        sum;
  logic [NodeIdBits-1:0] in_dest;
  logic [NodeIdBits-1:0] in_sender;
  logic [NodeIdBits-1:0] own_masked;
  logic                  vec_end;
  logic                  tail_changed;
  status_t               tail_status;

  assign sum        = {1'b0, req.data.link_cost} + {1'b0, req.data.adv_cost};
  assign in_dest    = req.data.dest_node[NodeIdBits-1:0];
  assign in_sender  = req.data.sender_node[NodeIdBits-1:0];
  assign own_masked = own_id[NodeIdBits-1:0];
  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;

  assign tail_status  = tail.hit ? tail.status : ST_FULL;
  assign tail_changed = item_update &&
                        (tail_status == ST_ADDED || tail_status == ST_IMPROVED);
  assign vec_end      = item_update && item_last;

  // cell row
  assign row[0] = head;
  for (genvar g = 1; g < TableDepth; g++) begin : g_cell
    dvru_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_index  (CountW'(g)),
      .route_total (total),
      .q_in        (row[g-1]),
      .q_out       (row[g])
    );
  end
  assign tail = row[TableDepth-1];

  always_comb begin
    state_next       = state;
    head_next        = head;
    head_next.valid  = 1'b0;
    res_next         = res;
    total_next       = total;
    flag_next        = changed_flag;
    out_load         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          head_next.act    = ACT_UPDATE;
          head_next.dest   = in_dest;
          head_next.sender = in_sender;
          head_next.cost   = sum[CostW-1:0];
          head_next.ridx   = req.data.read_index;
          head_next.hit    = 1'b0;
          head_next.status = ST_FULL;
          head_next.e_dest = '0;
          head_next.e_cost = '0;
          head_next.e_hop  = '0;
          res_next.status         = ST_READ_BAD;
          res_next.entry_dest     = '0;
          res_next.entry_cost     = '0;
          res_next.entry_next_hop = '0;
          res_next.route_count    = RouteCountW'(total);
          res_next.vector_changed = 1'b0;
          state_next              = S_HOLD;
          case (req.data.action)
            ACT_UPDATE: begin
              if (in_dest == own_masked) begin
                res_next.status = ST_SELF;
              end else if (sum >= {1'b0, infinity}) begin
                res_next.status = ST_UNREACH;
              end else begin
                head_next.valid = 1'b1;
                state_next      = S_RUN;
              end
              if (state_next == S_HOLD && req.data.last) begin
                res_next.vector_changed = changed_flag;
                flag_next               = 1'b0;
              end
            end
            ACT_INSTALL: begin
              head_next.act   = ACT_INSTALL;
              head_next.dest  = in_sender;
              head_next.cost  = req.data.link_cost;
              head_next.valid = 1'b1;
              state_next      = S_RUN;
            end
            ACT_READ: begin
              if (req.data.read_index == '0) begin
                res_next.status         = ST_READ_OK;
                res_next.entry_dest     = IdFieldW'(own_masked);
                res_next.entry_next_hop = IdFieldW'(own_masked);
              end else if (CountW'(req.data.read_index) < total) begin
                head_next.act   = ACT_READ;
                head_next.valid = 1'b1;
                state_next      = S_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (tail.valid) begin
          total_next = total + CountW'(tail_status == ST_ADDED);
          res_next.status         = tail_status;
          res_next.entry_dest     = tail.hit ? IdFieldW'(tail.e_dest) : '0;
          res_next.entry_cost     = tail.hit ? tail.e_cost : '0;
          res_next.entry_next_hop = tail.hit ? IdFieldW'(tail.e_hop) : '0;
          res_next.route_count    = RouteCountW'(total_next);
          res_next.vector_changed = vec_end && (changed_flag || tail_changed);
          flag_next               = vec_end ? 1'b0 : (changed_flag || tail_changed);
          state_next              = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total        <= CountW'(1);
      changed_flag <= 1'b0;
      rsp.valid    <= 1'b0;
      own_id       <= '0;
      infinity     <= InfinityReset;
    end else begin
      state        <= state_next;
      total        <= total_next;
      changed_flag <= flag_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_OWN_ID:   own_id   <= cfg_data[IdFieldW-1:0];
          CFG_INFINITY: infinity <= cfg_data[CostW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head <= head_next;
    end
    res <= res_next;
    if (accept) begin
      item_update <= (req.data.action == ACT_UPDATE);
      item_last   <= req.data.last;
    end
    if (out_load) begin
      rsp.data <= res;
    end
  end

  `DVRU_ASSERT_IMP(a_tail_in_run, tail.valid, state == S_RUN)
  `DVRU_ASSERT_IMP(a_total_range, 1'b1, total != '0 && total <= CountW'(TableDepth))
  `DVRU_ASSERT_NXT(a_total_held, !(state == S_RUN && tail.valid), $stable(total))
  `DVRU_ASSERT_NXT(a_head_after_accept, head.valid, !head.valid && state == S_RUN)

endmodule

### tb/distance_vector_route_update_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_update_tb
// self-checking bench for the route update engine: a table model predicts
// every response, random vectors, installs and reads run under several
// own-id and infinity settings with random stalls on both channels
// ----------------------------------------------------------------------------
module distance_vector_route_update_tb import dvru_pkg::*; ;

  class route_table_model;
    logic [IdFieldW-1:0] own_id;
    logic [CostW-1:0]    inf_cost;
    logic [IdFieldW-1:0] dest_tab [TableDepth];
    logic [CostW-1:0]    cost_tab [TableDepth];
    logic [IdFieldW-1:0] hop_tab  [TableDepth];
    int                  total;
    bit                  vec_changed;
    rsp_item_t           answers_due [$];
    int                  errors;
    int                  status_seen [8];

    function new();
      own_id      = '0;
      inf_cost    = InfinityReset;
      total       = 1;
      vec_changed = 1'b0;
      errors      = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_regs(logic [IdFieldW-1:0] id, logic [CostW-1:0] inf);
      own_id   = id;
      inf_cost = inf;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    function rsp_item_t with_entry(rsp_item_t a, int i);
      if (i == 0) begin
        a.entry_dest     = own_id;
        a.entry_cost     = '0;
        a.entry_next_hop = own_id;
      end else begin
        a.entry_dest     = dest_tab[i];
        a.entry_cost     = cost_tab[i];
        a.entry_next_hop = hop_tab[i];
      end
      return a;
    endfunction

    function bit append_route(logic [IdFieldW-1:0] d, logic [CostW-1:0] c,
                              logic [IdFieldW-1:0] h);
      if (total >= TableDepth) return 1'b0;
      dest_tab[total] = d;
      cost_tab[total] = c;
      hop_tab[total]  = h;
      total++;
      return 1'b1;
    endfunction

    function void accept_request(req_item_t rq);
      rsp_item_t      a;
      logic [CostW:0] sum;
      int             pos;
      bit             changed;
      a        = '0;
      a.status = ST_READ_BAD;
      changed  = 1'b0;
      pos      = -1;
      case (act_t'(rq.action))
        ACT_UPDATE: begin
          sum = rq.link_cost + rq.adv_cost;
          if (rq.dest_node == own_id) begin
            a.status = ST_SELF;
          end else if (sum >= inf_cost) begin
            a.status = ST_UNREACH;
          end else begin
            for (int i = 0; i < total && pos < 0; i++)
              if ((i == 0 ? own_id : dest_tab[i]) == rq.dest_node) pos = i;
            if (pos < 0) begin
              if (append_route(rq.dest_node, sum[CostW-1:0], rq.sender_node)) begin
                a        = with_entry(a, total - 1);
                a.status = ST_ADDED;
                changed  = 1'b1;
              end else begin
                a.status = ST_FULL;
              end
            end else begin
              a = with_entry(a, pos);
              if (pos != 0 && sum < a.entry_cost) begin
                cost_tab[pos]    = sum[CostW-1:0];
                hop_tab[pos]     = rq.sender_node;
                a.entry_cost     = sum[CostW-1:0];
                a.entry_next_hop = rq.sender_node;
                a.status         = ST_IMPROVED;
                changed          = 1'b1;
              end else begin
                a.status = ST_NOT_BETTER;
              end
            end
          end
          if (changed) vec_changed = 1'b1;
          if (rq.last) begin
            a.vector_changed = vec_changed;
            vec_changed      = 1'b0;
          end
        end
        ACT_INSTALL: begin
          if (append_route(rq.sender_node, rq.link_cost, rq.sender_node)) begin
            a        = with_entry(a, total - 1);
            a.status = ST_ADDED;
          end else begin
            a.status = ST_FULL;
          end
        end
        ACT_READ: begin
          if (rq.read_index < total) begin
            a        = with_entry(a, rq.read_index);
            a.status = ST_READ_OK;
          end
        end
        default: ;
      endcase
      a.route_count = total[RouteCountW-1:0];
      answers_due.push_back(a);
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        if (errors <= 20)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_answer(rsp_item_t act);
      rsp_item_t e;
      if (!$isunknown(act.status)) status_seen[act.status]++;
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected response, expected none, actual status %0d",
                   $time, act.status);
        return;
      end
      e = answers_due.pop_front();
      compare_field("status", e.status, act.status);
      compare_field("entry_dest", e.entry_dest, act.entry_dest);
      compare_field("entry_cost", e.entry_cost, act.entry_cost);
      compare_field("entry_next_hop", e.entry_next_hop, act.entry_next_hop);
      compare_field("route_count", e.route_count, act.route_count);
      compare_field("vector_changed", e.vector_changed, act.vector_changed);
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  dvru_req_if req_ch ();
  dvru_rsp_if rsp_ch ();

  distance_vector_route_update uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  route_table_model model = new();

  bit calm;
  bit hold_done;
  int answers_seen;
  int requests_sent;
  int settings_used;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      model.check_answer(rsp_ch.data);
      answers_seen++;
    end
  end

  // response side: random back-pressure plus one long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!hold_done && answers_seen >= 300) begin
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic offer(input logic [ActW-1:0] act, input logic [IdFieldW-1:0] snd,
                       input logic [IdFieldW-1:0] dst, input logic [CostW-1:0] adv,
                       input logic [CostW-1:0] lnk, input logic [ReadIdxW-1:0] idx,
                       input logic lst);
    req_item_t rq;
    rq.action      = act;
    rq.sender_node = snd;
    rq.dest_node   = dst;
    rq.adv_cost    = adv;
    rq.link_cost   = lnk;
    rq.read_index  = idx;
    rq.last        = lst;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= rq;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    model.accept_request(rq);
    requests_sent++;
  endtask

  // drain, then write the own-id register and then the infinity register
  task automatic program_regs(input logic [IdFieldW-1:0] id, input logic [CostW-1:0] inf);
    req_ch.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_ID;
    cfg_data  <= {8'($urandom), id};
    @(posedge clk);
    cfg_index <= CFG_INFINITY;
    cfg_data  <= inf;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.set_regs(id, inf);
    settings_used++;
  endtask

  function automatic logic [IdFieldW-1:0] pick_id();
    return ($urandom_range(0, 3) != 0) ? IdFieldW'($urandom_range(0, 19))
                                       : IdFieldW'($urandom_range(0, 255));
  endfunction

  function automatic logic [CostW-1:0] pick_cost();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return CostW'($urandom_range(0, 40));
    if (r < 9) return CostW'($urandom_range(0, 6000));
    return CostW'($urandom);
  endfunction

  task automatic run_phase(input int n);
    int                  done;
    int                  r;
    int                  len;
    logic [IdFieldW-1:0] snd;
    logic [CostW-1:0]    lnk;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        snd = pick_id();
        lnk = pick_cost();
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++)
          offer(ACT_UPDATE, snd, pick_id(), pick_cost(), lnk, 4'($urandom),
                j == len - 1);
        done += len;
      end else if (r < 80) begin
        offer(ACT_INSTALL, pick_id(), 8'($urandom), 16'($urandom), pick_cost(),
              4'($urandom), 1'($urandom));
        done++;
      end else if (r < 92) begin
        offer(ACT_READ, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              4'($urandom_range(0, 15)), 1'($urandom));
        done++;
      end else if (r < 97) begin
        offer(ACT_UPDATE, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              4'($urandom), 1'($urandom));
        done++;
      end else begin
        offer(2'd3, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              4'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    int wait_cycles;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_OWN_ID;
    cfg_data     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: own id 0, infinity 9999
    offer(ACT_READ,    8'd0,   8'd0,   16'd0,     16'd0,     4'd0,  1'b0);
    offer(ACT_READ,    8'd0,   8'd0,   16'd0,     16'd0,     4'd1,  1'b0);
    offer(ACT_READ,    8'd0,   8'd0,   16'd0,     16'd0,     4'd15, 1'b0);
    offer(2'd3,        8'hff,  8'hff,  16'hffff,  16'hffff,  4'hf,  1'b1);
    offer(ACT_UPDATE,  8'd3,   8'd0,   16'd5,     16'd5,     4'd0,  1'b1);
    offer(ACT_UPDATE,  8'd3,   8'd5,   16'hffff,  16'hffff,  4'd0,  1'b0);
    offer(ACT_UPDATE,  8'd3,   8'd5,   16'd9000,  16'd999,   4'd0,  1'b0);
    offer(ACT_UPDATE,  8'd3,   8'd5,   16'd9000,  16'd998,   4'd0,  1'b0);
    offer(ACT_UPDATE,  8'd9,   8'd5,   16'd20,    16'd10,    4'd0,  1'b1);
    offer(ACT_UPDATE,  8'd4,   8'd5,   16'd30,    16'd0,     4'd0,  1'b0);
    offer(ACT_UPDATE,  8'd4,   8'd5,   16'd100,   16'd0,     4'd0,  1'b1);
    offer(ACT_INSTALL, 8'hff,  8'd0,   16'd0,     16'hffff,  4'd0,  1'b0);
    offer(ACT_INSTALL, 8'd5,   8'd0,   16'd0,     16'd7,     4'd0,  1'b0);
    offer(ACT_INSTALL, 8'd0,   8'd0,   16'd0,     16'd1,     4'd0,  1'b0);
    offer(ACT_UPDATE,  8'd200, 8'hff,  16'd0,     16'd0,     4'd0,  1'b1);
    offer(ACT_UPDATE,  8'd1,   8'd5,   16'd1,     16'd0,     4'd0,  1'b0);
    offer(ACT_READ,    8'd0,   8'd0,   16'd0,     16'd0,     4'd3,  1'b0);
    offer(ACT_READ,    8'd0,   8'd0,   16'd0,     16'd0,     4'd4,  1'b0);
    offer(ACT_READ,    8'd0,   8'd0,   16'd0,     16'd0,     4'd5,  1'b0);
    offer(ACT_UPDATE,  8'd2,   8'd0,   16'd0,     16'd0,     4'd0,  1'b1);

    program_regs(8'hff, 16'd1);
    offer(ACT_READ,    8'd0,   8'd0,   16'd0,     16'd0,     4'd0,  1'b0);
    offer(ACT_UPDATE,  8'd7,   8'hff,  16'd0,     16'd0,     4'd0,  1'b0);
    offer(ACT_UPDATE,  8'd7,   8'd0,   16'd0,     16'd0,     4'd0,  1'b0);
    offer(ACT_UPDATE,  8'd7,   8'd9,   16'd0,     16'd0,     4'd0,  1'b0);
    offer(ACT_UPDATE,  8'd7,   8'd10,  16'd1,     16'd0,     4'd0,  1'b1);

    program_regs(8'd0, InfinityReset);
    run_phase(500);
    program_regs(8'd7, 16'hffff);
    run_phase(400);
    program_regs(8'hff, 16'd1);
    run_phase(200);
    program_regs(8'd0, 16'($urandom_range(50, 3000)));
    run_phase(400);
    program_regs(8'($urandom), InfinityReset);
    calm = 1'b1;
    run_phase(500);

    req_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (model.pending() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (30) @(posedge clk);
    if (model.pending() != 0) begin
      model.errors++;
      $display("%0t: %0d responses never arrived, expected 0 outstanding, actual %0d",
               $time, model.pending(), model.pending());
    end

    $display("covered %0d request transactions over %0d register settings, %0d routes at end",
             requests_sent, settings_used + 1, model.total);
    $display("statuses: added %0d improved %0d not-better %0d self %0d unreachable %0d full %0d read-ok %0d read-bad %0d",
             model.status_seen[ST_ADDED], model.status_seen[ST_IMPROVED],
             model.status_seen[ST_NOT_BETTER], model.status_seen[ST_SELF],
             model.status_seen[ST_UNREACH], model.status_seen[ST_FULL],
             model.status_seen[ST_READ_OK], model.status_seen[ST_READ_BAD]);
    if (model.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/dvru_pkg.sv
src/dvru_if.sv
src/dvru_cell.sv
src/distance_vector_route_update.sv
tb/distance_vector_route_update_tb.sv
